// ===== rtl/core/sspr_pkg.sv =====
// shared types and constants of the servo status packet receiver
package sspr_pkg;

    // header byte, masks and length constants
    localparam logic [7:0] HDR_BYTE    = 8'hFF;
    localparam logic [7:0] CHK_MASK    = 8'hFE;
    localparam logic [7:0] FLAG_MASK   = 8'hFD;
    localparam logic [7:0] MIN_LEN     = 8'd9;
    localparam logic [7:0] FIXED_BYTES = 8'd7;

    // input kinds
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    // register indexes
    localparam logic REG_EXPECTED_ID = 1'b0;
    localparam logic REG_MAX_LENGTH  = 1'b1;

    // verdict codes
    typedef enum logic [2:0] {
        V_PAYLOAD      = 3'd0,
        V_OK           = 3'd1,
        V_ID_MISMATCH  = 3'd2,
        V_CHECKSUM_BAD = 3'd3,
        V_BAD_LENGTH   = 3'd4,
        V_TIMEOUT_EMPTY   = 3'd5,
        V_TIMEOUT_PARTIAL = 3'd6
    } verdict_t;

    // parser phases
    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_HDR  = 3'd1,
        PH_LEN  = 3'd2,
        PH_ID   = 3'd3,
        PH_CMD  = 3'd4,
        PH_CK1  = 3'd5,
        PH_CK2  = 3'd6,
        PH_DATA = 3'd7
    } phase_t;

    // one result item
    typedef struct packed {
        verdict_t   verdict;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] command_code;
        logic [7:0] error_flags;
        logic [7:0] status_detail;
        logic       last;
    } result_t;

endpackage

// ===== rtl/core/servo_status_packet_receiver_core.sv =====
// top level of the servo status packet receiver
//
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tdata rx_byte, s_tuser kind
// m_        out  m_tvalid/m_tready  m_tdata 40 bits, m_tuser verdict, m_tlast
// apb       in   psel/penable       expected_id at 0x0, max_length at 0x4
//
// one item per cycle sustained while m_ is not stalled; a result, for an item that gives one,
// passes the input register, one parser step and the result register before it shows on m_.
// reset clears the parser to header hunting and the registers to their defaults.
// a stalled m_ side holds the result register; the input register keeps one
// more item, then s_tready drops.
module servo_status_packet_receiver_core
    import sspr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] kind
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] payload_byte, [15:8] payload_index,
                                   // [23:16] command_code, [31:24] error_flags,
                                   // [39:32] status_detail
    output logic [2:0]  m_tuser,   // [2:0] verdict
    output logic        m_tlast,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       in_valid_reg;
    logic       in_kind_reg;
    logic [7:0] in_byte_reg;
    logic [7:0] expected_id_reg;
    logic [7:0] max_length_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    logic       out_free;
    logic       step;
    logic       res_valid;
    result_t    res;
    logic       cfg_write;
    logic       cfg_index;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[2];
    assign prdata    = (cfg_index == REG_MAX_LENGTH) ? {24'd0, max_length_reg}
                                                    : {24'd0, expected_id_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_id_reg <= 8'd0;
            max_length_reg  <= 8'd223;
        end else if (cfg_write) begin
            if (cfg_index == REG_EXPECTED_ID) begin
                expected_id_reg <= pwdata[7:0];
            end else begin
                max_length_reg <= pwdata[7:0];
            end
        end
    end

    // handshake between the stages
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || step;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    sspr_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .kind        (in_kind_reg),
        .rx_byte     (in_byte_reg),
        .expected_id (expected_id_reg),
        .max_length  (max_length_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.status_detail, out_reg.error_flags, out_reg.command_code,
                       out_reg.payload_index, out_reg.payload_byte};
    assign m_tuser  = out_reg.verdict;
    assign m_tlast  = out_reg.last;

    // a mid-packet result is always a payload transfer
    a_mid_is_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser == V_PAYLOAD)
        else $error("non-last result carries an ending verdict");

    // an ending result never carries the payload code
    a_last_not_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser != V_PAYLOAD)
        else $error("last result carries the payload verdict");

    // length and timeout verdicts carry an all-zero data word
    a_empty_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == V_BAD_LENGTH || m_tuser == V_TIMEOUT_EMPTY
                     || m_tuser == V_TIMEOUT_PARTIAL) |-> m_tdata == '0)
        else $error("framing verdict with nonzero data");

    // a held input item is not dropped while the output is blocked
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_byte_reg)
                                      && $stable(in_kind_reg))
        else $error("pending input item lost under stall");

endmodule

// ===== rtl/core/sspr_parser.sv =====
// packet parser state and per-item step logic
module sspr_parser
    import sspr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic       kind,
    input  logic [7:0] rx_byte,
    input  logic [7:0] expected_id,
    input  logic [7:0] max_length,
    output logic       res_valid,
    output result_t    res
);

    phase_t     phase_reg,         phase_next;
    logic [7:0] byte_count_reg,    byte_count_next;
    logic [7:0] packet_length_reg, packet_length_next;
    logic [7:0] running_xor_reg,   running_xor_next;
    logic [7:0] received_id_reg,   received_id_next;
    logic [7:0] command_seen_reg,  command_seen_next;
    logic [7:0] check_low_reg,     check_low_next;
    logic [7:0] check_high_reg,    check_high_next;
    logic [7:0] previous_byte_reg, previous_byte_next;
    logic       any_seen_reg,      any_seen_next;

    logic [7:0] xor_data;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [8:0] idx_plus;
    logic [8:0] total;
    logic       end_data;

    // checksum and end-of-payload terms for a data byte
    assign xor_data = running_xor_reg ^ rx_byte;
    assign c1       = xor_data & CHK_MASK;
    assign c2       = (~c1) & CHK_MASK;
    assign idx_plus = {1'b0, byte_count_reg} + 9'd1;
    assign total    = {1'b0, packet_length_reg} - {1'b0, FIXED_BYTES};
    assign end_data = (idx_plus >= total);

    // next state and result
    always_comb begin
        phase_next         = phase_reg;
        byte_count_next    = byte_count_reg;
        packet_length_next = packet_length_reg;
        running_xor_next   = running_xor_reg;
        received_id_next   = received_id_reg;
        command_seen_next  = command_seen_reg;
        check_low_next     = check_low_reg;
        check_high_next    = check_high_reg;
        previous_byte_next = previous_byte_reg;
        any_seen_next      = any_seen_reg;
        res_valid          = 1'b0;
        res                = '0;
        res.verdict        = V_PAYLOAD;

        if (kind == KIND_TIMEOUT) begin
            res_valid   = 1'b1;
            res.verdict = any_seen_reg ? V_TIMEOUT_PARTIAL : V_TIMEOUT_EMPTY;
            res.last    = 1'b1;
        end else begin
            any_seen_next = 1'b1;
            unique case (phase_reg)
                PH_HUNT: begin
                    if (rx_byte == HDR_BYTE) begin
                        phase_next = PH_HDR;
                    end
                end
                PH_HDR: begin
                    phase_next = (rx_byte == HDR_BYTE) ? PH_LEN : PH_HUNT;
                end
                PH_LEN: begin
                    if (rx_byte < MIN_LEN || rx_byte > max_length) begin
                        res_valid   = 1'b1;
                        res.verdict = V_BAD_LENGTH;
                        res.last    = 1'b1;
                    end else begin
                        packet_length_next = rx_byte;
                        running_xor_next   = rx_byte;
                        byte_count_next    = '0;
                        phase_next         = PH_ID;
                    end
                end
                PH_ID: begin
                    received_id_next = rx_byte;
                    running_xor_next = xor_data;
                    phase_next       = PH_CMD;
                end
                PH_CMD: begin
                    command_seen_next = rx_byte;
                    running_xor_next  = xor_data;
                    phase_next        = PH_CK1;
                end
                PH_CK1: begin
                    check_low_next = rx_byte;
                    phase_next     = PH_CK2;
                end
                PH_CK2: begin
                    check_high_next = rx_byte;
                    phase_next      = PH_DATA;
                end
                PH_DATA: begin
                    res_valid         = 1'b1;
                    res.payload_byte  = rx_byte;
                    res.payload_index = byte_count_reg;
                    res.command_code  = command_seen_reg;
                    running_xor_next  = xor_data;
                    if (end_data) begin
                        res.error_flags   = previous_byte_reg & FLAG_MASK;
                        res.status_detail = rx_byte & FLAG_MASK;
                        res.last          = 1'b1;
                        priority if (received_id_reg != expected_id) begin
                            res.verdict = V_ID_MISMATCH;
                        end else if (check_low_reg != c1 || check_high_reg != c2) begin
                            res.verdict = V_CHECKSUM_BAD;
                        end else begin
                            res.verdict = V_OK;
                        end
                    end else begin
                        previous_byte_next = rx_byte;
                        byte_count_next    = idx_plus[7:0];
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end

        // any ending result clears the packet context
        if (res_valid && res.last) begin
            phase_next         = PH_HUNT;
            byte_count_next    = '0;
            packet_length_next = '0;
            running_xor_next   = '0;
            received_id_next   = '0;
            command_seen_next  = '0;
            check_low_next     = '0;
            check_high_next    = '0;
            previous_byte_next = '0;
            any_seen_next      = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_HUNT;
            byte_count_reg    <= '0;
            packet_length_reg <= '0;
            running_xor_reg   <= '0;
            received_id_reg   <= '0;
            command_seen_reg  <= '0;
            check_low_reg     <= '0;
            check_high_reg    <= '0;
            previous_byte_reg <= '0;
            any_seen_reg      <= 1'b0;
        end else if (step) begin
            phase_reg         <= phase_next;
            byte_count_reg    <= byte_count_next;
            packet_length_reg <= packet_length_next;
            running_xor_reg   <= running_xor_next;
            received_id_reg   <= received_id_next;
            command_seen_reg  <= command_seen_next;
            check_low_reg     <= check_low_next;
            check_high_reg    <= check_high_next;
            previous_byte_reg <= previous_byte_next;
            any_seen_reg      <= any_seen_next;
        end
    end

endmodule
